// ===== hw/rtl/wsfd_pkg.sv =====
`timescale 1ns / 1ps

package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASKKEY = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   localparam logic [1:0] ACT_TEXT  = 2'd0;
   localparam logic [1:0] ACT_PING  = 2'd1;
   localparam logic [1:0] ACT_CLOSE = 2'd2;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       empty_frame;
      logic       last;
   } rsp_type;

endpackage

// ===== hw/rtl/wsfd_parser.sv =====
`timescale 1ns / 1ps

module wsfd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       rx_byte,
   output logic             rsp_valid,
   output wsfd_pkg::rsp_type rsp
);
   import wsfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  midx_ff, midx_in;
   logic        closed_ff, closed_in;

   logic        len_done;
   logic        hdr_done;
   logic        pay_step;
   logic        fin;
   logic        no_payload;
   logic [7:0]  key_byte;
   logic [7:0]  plain;

   assign fin        = (remain_ff == 64'd1);
   assign no_payload = (remain_in == 64'd0);

   // Next state of the parser.
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      opcode_in  = opcode_ff;
      mask_in    = mask_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      midx_in    = midx_ff;
      closed_in  = closed_ff;
      len_done   = 1'b0;
      hdr_done   = 1'b0;
      pay_step   = 1'b0;
      if (byte_valid && !closed_ff) begin
         case (phase_ff)
            PH_HDR1: begin
               mask_in = rx_byte[7];
               if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
                  remain_in  = 64'd0;
                  hdr_cnt_in = (rx_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  phase_in   = PH_EXTLEN;
               end else begin
                  remain_in = {57'd0, rx_byte[6:0]};
                  len_done  = 1'b1;
               end
            end
            PH_EXTLEN: begin
               remain_in  = {remain_ff[55:0], rx_byte};
               hdr_cnt_in = hdr_cnt_ff - 4'd1;
               len_done   = (hdr_cnt_in == 4'd0);
            end
            PH_MASKKEY: begin
               key_in     = {key_ff[23:0], rx_byte};
               hdr_cnt_in = hdr_cnt_ff - 4'd1;
               hdr_done   = (hdr_cnt_in == 4'd0);
            end
            PH_PAYLOAD: begin
               pay_step  = 1'b1;
               midx_in   = midx_ff + 2'd1;
               remain_in = remain_ff - 64'd1;
               if (fin) begin
                  phase_in = PH_HDR0;
                  if (opcode_ff == OP_CLOSE) begin
                     closed_in = 1'b1;
                  end
               end
            end
            default: begin
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase

         if (len_done) begin
            if (mask_in) begin
               phase_in   = PH_MASKKEY;
               hdr_cnt_in = KEY_BYTES;
            end else begin
               hdr_done = 1'b1;
            end
         end

         if (hdr_done) begin
            midx_in = 2'd0;
            if (no_payload) begin
               phase_in = PH_HDR0;
               if (opcode_ff == OP_CLOSE) begin
                  closed_in = 1'b1;
               end
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   always_comb begin
      case (midx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign plain = mask_ff ? (rx_byte ^ key_byte) : rx_byte;

   // Result produced by the accepted byte, if any.
   always_comb begin
      rsp_valid = 1'b0;
      rsp       = '0;
      if (hdr_done && no_payload) begin
         case (opcode_ff)
            OP_TEXT: begin
               rsp_valid = 1'b1;
               rsp       = '{action: ACT_TEXT, data_byte: 8'd0, empty_frame: 1'b1, last: 1'b1};
            end
            OP_PING: begin
               rsp_valid = 1'b1;
               rsp       = '{action: ACT_PING, data_byte: 8'd0, empty_frame: 1'b1, last: 1'b1};
            end
            OP_CLOSE: begin
               rsp_valid = 1'b1;
               rsp       = '{action: ACT_CLOSE, data_byte: 8'd0, empty_frame: 1'b0, last: 1'b1};
            end
            default: begin
               rsp_valid = 1'b0;
            end
         endcase
      end else if (pay_step) begin
         case (opcode_ff)
            OP_TEXT: begin
               rsp_valid = 1'b1;
               rsp       = '{action: ACT_TEXT, data_byte: plain, empty_frame: 1'b0, last: fin};
            end
            OP_PING: begin
               rsp_valid = 1'b1;
               rsp       = '{action: ACT_PING, data_byte: plain, empty_frame: 1'b0, last: fin};
            end
            OP_CLOSE: begin
               rsp_valid = fin;
               rsp       = '{action: ACT_CLOSE, data_byte: 8'd0, empty_frame: 1'b0, last: 1'b1};
            end
            default: begin
               rsp_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         hdr_cnt_ff <= 4'd0;
         opcode_ff  <= 4'd0;
         mask_ff    <= 1'b0;
         remain_ff  <= 64'd0;
         key_ff     <= 32'd0;
         midx_ff    <= 2'd0;
         closed_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         opcode_ff  <= opcode_in;
         mask_ff    <= mask_in;
         remain_ff  <= remain_in;
         key_ff     <= key_in;
         midx_ff    <= midx_in;
         closed_ff  <= closed_in;
      end
   end

endmodule

// ===== hw/rtl/wsfd_queue.sv =====
`timescale 1ns / 1ps

module wsfd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  wsfd_pkg::rsp_type wr_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output wsfd_pkg::rsp_type head
);
   import wsfd_pkg::*;

   rsp_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_wr;
   logic                do_rd;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = pop && !empty;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_wr) - QCNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// Receive-side WebSocket frame parser. Bytes of the frame stream go in on
// the input queue port: a transfer happens on a clock edge with push high
// and full low. Frame headers are parsed, payload bytes are unmasked, and
// text and ping payload bytes, empty-frame markers and the close notice
// come out on the result queue port, one transfer per edge with pop high
// and empty low. The oldest result stays on the rsp_ ports while empty is
// low.
// One byte is taken every cycle while full is low. A result written by a
// byte is visible the cycle after its transfer, from a four-entry result
// queue that sits between the parser and the output. When the receiver
// stops popping, the queue fills and full holds off further bytes; header
// bytes and bytes of other opcodes still need a free entry to be taken.
// After a close frame every further byte is accepted and dropped until
// reset. Synchronous reset returns the parser to the start of a frame and
// empties the queue; both are ready in the first cycle after reset.
module websocket_frame_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_rx_byte,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_action,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_empty_frame,
   output logic       rsp_last
);
   import wsfd_pkg::*;

   logic    byte_valid;
   logic    res_valid;
   rsp_type res;
   rsp_type head;

   assign byte_valid = push && !full;

   wsfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .rsp_valid  (res_valid),
      .rsp        (res)
   );

   wsfd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid),
      .wr_data (res),
      .full    (full),
      .empty   (empty),
      .pop     (pop),
      .head    (head)
   );

   assign rsp_action      = head.action;
   assign rsp_data_byte   = head.data_byte;
   assign rsp_empty_frame = head.empty_frame;
   assign rsp_last        = head.last;

endmodule

// ===== hw/rtl/wsfd_checker.sv =====
`timescale 1ns / 1ps

module wsfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [1:0] rsp_action,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_empty_frame,
   input logic       rsp_last
);
   import wsfd_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queue not empty or full after reset");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_action) && $stable(rsp_data_byte)
         && $stable(rsp_empty_frame) && $stable(rsp_last))
      else $error("waiting result changed before its transfer");

   a_action_known: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_action == ACT_TEXT || rsp_action == ACT_PING
         || rsp_action == ACT_CLOSE)
      else $error("undefined action code");

   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_empty_frame |-> rsp_last && rsp_data_byte == 8'd0
         && rsp_action != ACT_CLOSE)
      else $error("malformed empty-frame marker");

   a_close_form: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_action == ACT_CLOSE |-> rsp_last && !rsp_empty_frame
         && rsp_data_byte == 8'd0)
      else $error("malformed close result");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_action      (rsp_action),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_empty_frame (rsp_empty_frame),
   .rsp_last        (rsp_last)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import wsfd_pkg::*;

   typedef enum int {FORM_7, FORM_16, FORM_64} len_form_type;
   typedef enum int {END_CLOSE_EMPTY, END_CLOSE_PAYLOAD, END_HUGE_TEXT} ending_kind_type;

   typedef struct {
      logic [7:0] rx_byte;
      bit         typed;
      bit         has_rsp;
      rsp_type    rsp;
   } stim_row_type;

   localparam rsp_type NO_RSP = '0;
   localparam int RANDOM_END = 1390;
   localparam int CALM_FROM = 1250;
   localparam int DRAIN_PAUSE_AT = 700;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       pop = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       full;
   logic       empty;
   logic [1:0] rsp_action;
   logic [7:0] rsp_data_byte;
   logic       rsp_empty_frame;
   logic       rsp_last;

   // Parser state as the byte stream has advanced it so far.
   phase_type   dp_phase = PH_HDR0;
   logic [3:0]  dp_count = '0;
   logic [3:0]  dp_opcode = '0;
   logic        dp_masked = 1'b0;
   logic [63:0] dp_remaining = '0;
   logic [31:0] dp_key = '0;
   logic [1:0]  dp_key_idx = '0;
   logic        dp_closed = 1'b0;

   rsp_type      expected_rsp[$];
   stim_row_type stim_table[$];
   rsp_type      want_rsp;
   int        fail_count = 0;
   int        items_sent = 0;
   int        results_seen = 0;
   int        n_text_frames = 0;
   int        n_ping_frames = 0;
   int        n_other_frames = 0;
   bit        calm = 1'b0;
   bit        long_hold_done = 1'b0;
   ending_kind_type ending;

   websocket_frame_deframer_core u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_rx_byte     (req_rx_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_action      (rsp_action),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_empty_frame (rsp_empty_frame),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic rsp_type rsp_of(input logic [1:0] act, input logic [7:0] d,
                                      input logic e, input logic l);
      rsp_type r;
      r.action      = act;
      r.data_byte   = d;
      r.empty_frame = e;
      r.last        = l;
      return r;
   endfunction

   // Header is complete: a zero-length text, ping or close frame reports at once.
   task automatic header_complete(output bit produced, output rsp_type r);
      dp_key_idx = '0;
      produced = 1'b0;
      r = NO_RSP;
      if (dp_remaining != 0) begin
         dp_phase = PH_PAYLOAD;
      end else begin
         dp_phase = PH_HDR0;
         if (dp_opcode == OP_TEXT) begin
            produced = 1'b1;
            r = rsp_of(ACT_TEXT, 8'h00, 1'b1, 1'b1);
         end else if (dp_opcode == OP_PING) begin
            produced = 1'b1;
            r = rsp_of(ACT_PING, 8'h00, 1'b1, 1'b1);
         end else if (dp_opcode == OP_CLOSE) begin
            dp_closed = 1'b1;
            produced = 1'b1;
            r = rsp_of(ACT_CLOSE, 8'h00, 1'b0, 1'b1);
         end
      end
   endtask

   task automatic length_known(output bit produced, output rsp_type r);
      produced = 1'b0;
      r = NO_RSP;
      if (dp_masked) begin
         dp_phase = PH_MASKKEY;
         dp_count = KEY_BYTES;
      end else begin
         header_complete(produced, r);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b, output bit produced, output rsp_type r);
      logic [7:0] plain;
      bit         frame_end;
      produced = 1'b0;
      r = NO_RSP;
      if (!dp_closed) begin
         case (dp_phase)
            PH_HDR1: begin
               dp_masked = b[7];
               if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                  dp_remaining = '0;
                  dp_count = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  dp_phase = PH_EXTLEN;
               end else begin
                  dp_remaining = {57'd0, b[6:0]};
                  length_known(produced, r);
               end
            end
            PH_EXTLEN: begin
               dp_remaining = {dp_remaining[55:0], b};
               dp_count = dp_count - 4'd1;
               if (dp_count == 0) length_known(produced, r);
            end
            PH_MASKKEY: begin
               dp_key = {dp_key[23:0], b};
               dp_count = dp_count - 4'd1;
               if (dp_count == 0) header_complete(produced, r);
            end
            PH_PAYLOAD: begin
               plain = dp_masked ? (b ^ dp_key[8 * (3 - dp_key_idx) +: 8]) : b;
               dp_key_idx = dp_key_idx + 2'd1;
               dp_remaining = dp_remaining - 64'd1;
               frame_end = (dp_remaining == 0);
               if (frame_end) dp_phase = PH_HDR0;
               if (dp_opcode == OP_TEXT) begin
                  produced = 1'b1;
                  r = rsp_of(ACT_TEXT, plain, 1'b0, frame_end);
               end else if (dp_opcode == OP_PING) begin
                  produced = 1'b1;
                  r = rsp_of(ACT_PING, plain, 1'b0, frame_end);
               end else if (dp_opcode == OP_CLOSE && frame_end) begin
                  dp_closed = 1'b1;
                  produced = 1'b1;
                  r = rsp_of(ACT_CLOSE, 8'h00, 1'b0, 1'b1);
               end
            end
            default: begin
               dp_opcode = b[3:0];
               dp_phase = PH_HDR1;
            end
         endcase
      end
   endtask

   // One byte transfer; a typed row overrides what the predictor says it causes.
   task automatic offer_byte(input logic [7:0] b, input bit typed, input bit t_has,
                             input rsp_type t_rsp);
      bit      p_has;
      rsp_type p_rsp;
      if (!calm && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      deframe_byte(b, p_has, p_rsp);
      if (typed) begin
         p_has = t_has;
         p_rsp = t_rsp;
      end
      if (p_has) expected_rsp.push_back(p_rsp);
      items_sent++;
   endtask

   task automatic send_frame(input logic [3:0] opc, input bit masked, input logic [63:0] len,
                             input len_form_type form, input int n_payload);
      logic [3:0]  hi;
      logic [31:0] key;
      hi = 4'($urandom_range(0, 15));
      key = $urandom;
      if (opc == OP_TEXT) n_text_frames++;
      else if (opc == OP_PING) n_ping_frames++;
      else n_other_frames++;
      offer_byte({hi, opc}, 1'b0, 1'b0, NO_RSP);
      case (form)
         FORM_16: begin
            offer_byte({masked, LEN_EXT16}, 1'b0, 1'b0, NO_RSP);
            offer_byte(len[15:8], 1'b0, 1'b0, NO_RSP);
            offer_byte(len[7:0], 1'b0, 1'b0, NO_RSP);
         end
         FORM_64: begin
            offer_byte({masked, LEN_EXT64}, 1'b0, 1'b0, NO_RSP);
            for (int i = 7; i >= 0; i--) offer_byte(len[8 * i +: 8], 1'b0, 1'b0, NO_RSP);
         end
         default: offer_byte({masked, len[6:0]}, 1'b0, 1'b0, NO_RSP);
      endcase
      if (masked) begin
         for (int i = 3; i >= 0; i--) offer_byte(key[8 * i +: 8], 1'b0, 1'b0, NO_RSP);
      end
      repeat (n_payload) offer_byte(8'($urandom), 1'b0, 1'b0, NO_RSP);
   endtask

   task automatic row_pred(input logic [7:0] b);
      stim_row_type row;
      row.rx_byte = b;
      row.typed = 1'b0;
      row.has_rsp = 1'b0;
      row.rsp = NO_RSP;
      stim_table.push_back(row);
   endtask

   task automatic row_typed(input logic [7:0] b, input bit has, input rsp_type r);
      stim_row_type row;
      row.rx_byte = b;
      row.typed = 1'b1;
      row.has_rsp = has;
      row.rsp = r;
      stim_table.push_back(row);
   endtask

   task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
         fail_count++;
      end
   endtask

   // Result side: every transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: result with none expected: action %0d data 0x%0h empty %0b last %0b",
                     $time, rsp_action, rsp_data_byte, rsp_empty_frame, rsp_last);
            fail_count++;
         end else begin
            want_rsp = expected_rsp.pop_front();
            check_field("action", 8'(want_rsp.action), 8'(rsp_action));
            check_field("data_byte", want_rsp.data_byte, rsp_data_byte);
            check_field("empty_frame", 8'(want_rsp.empty_frame), 8'(rsp_empty_frame));
            check_field("last", 8'(want_rsp.last), 8'(rsp_last));
         end
         results_seen++;
      end
   end

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && results_seen >= 300) begin
            // Hold off long enough for the result queue to fill and stall the input.
            long_hold_done = 1'b1;
            pop <= 1'b0;
            repeat (80) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Run timed out with %0d results still expected.", expected_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [3:0]  opc;
      logic [63:0] len;
      len_form_type form;
      int          pick;
      int          n;
      bit          drained;
      drained = 1'b0;

      // Zero-length text and ping frames give a single empty marker.
      row_typed(8'h81, 1'b0, NO_RSP);
      row_typed(8'h00, 1'b1, rsp_of(ACT_TEXT, 8'h00, 1'b1, 1'b1));
      row_typed(8'h89, 1'b0, NO_RSP);
      row_typed(8'h00, 1'b1, rsp_of(ACT_PING, 8'h00, 1'b1, 1'b1));
      // Masked text of four bytes, one per key byte.
      row_pred(8'h81);
      row_pred(8'h84);
      row_pred(8'hFF);
      row_pred(8'h00);
      row_pred(8'hA5);
      row_pred(8'h5A);
      row_pred(8'h00);
      row_pred(8'hFF);
      row_pred(8'h5A);
      row_pred(8'h00);
      // Ping with a 16-bit extended length of zero, FIN clear.
      row_pred(8'h09);
      row_pred(8'h7E);
      row_pred(8'h00);
      row_typed(8'h00, 1'b1, rsp_of(ACT_PING, 8'h00, 1'b1, 1'b1));
      // Text with a 64-bit extended length of one.
      row_pred(8'h01);
      row_pred(8'h7F);
      repeat (7) row_pred(8'h00);
      row_pred(8'h01);
      row_typed(8'hFF, 1'b1, rsp_of(ACT_TEXT, 8'hFF, 1'b0, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         offer_byte(stim_table[i].rx_byte, stim_table[i].typed, stim_table[i].has_rsp,
                    stim_table[i].rsp);

      while (items_sent < RANDOM_END) begin
         if (!drained && items_sent >= DRAIN_PAUSE_AT) begin
            drained = 1'b1;
            push <= 1'b0;
            while (expected_rsp.size() != 0) @(posedge clock);
            repeat (4) @(posedge clock);
         end
         if (items_sent >= CALM_FROM) calm = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            opc = OP_TEXT;
         end else if (pick < 75) begin
            opc = OP_PING;
         end else begin
            // Close is kept for the end since nothing follows it before reset.
            do opc = 4'($urandom_range(0, 15));
            while (opc == OP_TEXT || opc == OP_PING || opc == OP_CLOSE);
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            form = FORM_7;
            len = 64'($urandom_range(0, 8));
         end else if (pick < 68) begin
            form = FORM_7;
            len = 64'($urandom_range(9, 125));
         end else if (pick < 83) begin
            form = FORM_16;
            len = 64'($urandom_range(0, 12));
         end else if (pick < 85) begin
            form = FORM_16;
            len = 64'($urandom_range(126, 300));
         end else begin
            form = FORM_64;
            len = 64'($urandom_range(0, 12));
         end
         send_frame(opc, 1'($urandom_range(0, 1)), len, form, int'(len));
      end

      calm = 1'b1;
      ending = ending_kind_type'($urandom_range(0, 2));
      case (ending)
         END_CLOSE_EMPTY: send_frame(OP_CLOSE, 1'($urandom_range(0, 1)), 64'd0, FORM_7, 0);
         END_CLOSE_PAYLOAD: begin
            n = $urandom_range(1, 5);
            send_frame(OP_CLOSE, 1'($urandom_range(0, 1)), 64'(n), FORM_7, n);
         end
         default: send_frame(OP_TEXT, 1'($urandom_range(0, 1)), {1'b1, 62'd0, 1'b1},
                             FORM_64, 24);
      endcase
      // After a close these are dropped; after the endless text frame they are payload.
      repeat (20) offer_byte(8'($urandom), 1'b0, 1'b0, NO_RSP);

      push <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d byte transfers: %0d text, %0d ping and %0d other-opcode frames,",
               items_sent, n_text_frames, n_ping_frames, n_other_frames);
      $display("%0d results checked; stream ended with %s.", results_seen, ending.name());
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
